/* sv/fhcg_pkg.sv */
`timescale 1ns / 1ps

package fhcg_pkg;

    // Detector geometry.
    localparam int unsigned POSITIONS             = 16;
    localparam int unsigned CRYSTALS_PER_POSITION = 4;
    localparam int unsigned NUM_CRYSTALS          = POSITIONS * CRYSTALS_PER_POSITION;

    // Field widths.
    localparam int unsigned CRYSTAL_W = 6;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned GATE_W    = 31;
    localparam int unsigned MASK_W    = 64;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned LIMIT_W   = TIME_W + 1;

    localparam int unsigned MIN_SURVIVORS = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 72;

    // Configuration register indexes.
    localparam logic CFG_GATE_TICKS      = 1'b0;
    localparam logic CFG_CORRELATED_MODE = 1'b1;

    // Last crystal visited by the evaluation pass.
    localparam logic [CRYSTAL_W-1:0] LAST_IDX = CRYSTAL_W'(NUM_CRYSTALS - 1);

    // Per-event bookkeeping held outside the time memory.
    typedef struct packed {
        logic [MASK_W-1:0] valid_mask;
        logic [MASK_W-1:0] raw_mask;
        logic [TIME_W-1:0] earliest;
    } t_event;

    // Write port of the time memory.
    typedef struct packed {
        logic                 we;
        logic [CRYSTAL_W-1:0] addr;
        logic [TIME_W-1:0]    data;
    } t_ram_wr;

endpackage

/* sv/fhcg_ram.sv */
`timescale 1ns / 1ps

module fhcg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fhcg_event.sv */
`timescale 1ns / 1ps

module fhcg_event (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_beat,
    input  logic                                i_clear,
    input  logic [fhcg_pkg::CRYSTAL_W-1:0]      i_crystal,
    input  logic                                i_raw_hit,
    input  logic                                i_cal_valid,
    input  logic [fhcg_pkg::TIME_W-1:0]         i_hit_time,
    output fhcg_pkg::t_event                    o_evt,
    output fhcg_pkg::t_ram_wr                   o_wr
);

    logic [fhcg_pkg::MASK_W-1:0] r_valid_mask;
    logic [fhcg_pkg::MASK_W-1:0] r_raw_mask;
    logic [fhcg_pkg::TIME_W-1:0] r_earliest;
    logic                        r_have_earliest;
    logic                        in_range;
    logic                        earlier;

    // Indexes beyond the fitted crystals are dropped from storage.
    assign in_range = ({1'b0, i_crystal} < (fhcg_pkg::CRYSTAL_W + 1)'(fhcg_pkg::NUM_CRYSTALS));
    assign earlier  = !r_have_earliest || ($signed(i_hit_time) < $signed(r_earliest));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mask    <= '0;
            r_raw_mask      <= '0;
            r_earliest      <= '0;
            r_have_earliest <= 1'b0;
        end else begin
            priority if (i_clear) begin
                r_valid_mask    <= '0;
                r_raw_mask      <= '0;
                r_earliest      <= '0;
                r_have_earliest <= 1'b0;
            end else if (i_beat && in_range) begin
                if (i_raw_hit) begin
                    r_raw_mask[i_crystal] <= 1'b1;
                end
                if (i_cal_valid) begin
                    r_valid_mask[i_crystal] <= 1'b1;
                    if (earlier) begin
                        r_earliest      <= i_hit_time;
                        r_have_earliest <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_evt.valid_mask = r_valid_mask;
    assign o_evt.raw_mask   = r_raw_mask;
    assign o_evt.earliest   = r_earliest;

    assign o_wr.we   = i_beat && in_range && i_cal_valid;
    assign o_wr.addr = i_crystal;
    assign o_wr.data = i_hit_time;

endmodule

/* sv/fhcg_scan.sv */
`timescale 1ns / 1ps

module fhcg_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [fhcg_pkg::GATE_W-1:0]         i_gate_ticks,
    input  logic                                i_correlated,
    input  fhcg_pkg::t_event                    i_evt,
    input  logic [fhcg_pkg::TIME_W-1:0]         i_rd_data,
    output logic [fhcg_pkg::CRYSTAL_W-1:0]      o_rd_addr,
    output logic                                o_done,
    output logic [fhcg_pkg::MASK_W-1:0]         o_keep,
    output logic [fhcg_pkg::COUNT_W-1:0]        o_count
);

    logic                           r_prep;
    logic                           r_issue;
    logic                           r_chk;
    logic                           r_done;
    logic [fhcg_pkg::CRYSTAL_W-1:0] r_addr;
    logic [fhcg_pkg::CRYSTAL_W-1:0] r_chk_idx;
    logic [fhcg_pkg::LIMIT_W-1:0]   r_limit;
    logic [fhcg_pkg::MASK_W-1:0]    r_keep;
    logic [fhcg_pkg::COUNT_W-1:0]   r_count;
    logic [fhcg_pkg::LIMIT_W-1:0]   n_limit;
    logic [fhcg_pkg::LIMIT_W-1:0]   stored_ext;
    logic                           in_gate;
    logic                           kept;

    // The limit is formed one bit wider than a time so that it never wraps.
    assign n_limit    = {i_evt.earliest[fhcg_pkg::TIME_W-1], i_evt.earliest}
                      + {2'b00, i_gate_ticks};
    assign stored_ext = {i_rd_data[fhcg_pkg::TIME_W-1], i_rd_data};
    assign in_gate    = $signed(stored_ext) <= $signed(r_limit);
    assign kept       = i_evt.valid_mask[r_chk_idx] && i_evt.raw_mask[r_chk_idx]
                      && (i_correlated ? in_gate : !in_gate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep  <= 1'b0;
            r_issue <= 1'b0;
            r_chk   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            // Register the start so that the earliest time has settled before the limit is taken.
            r_prep <= i_start;
            r_chk  <= r_issue;
            r_done <= r_chk && (r_chk_idx == fhcg_pkg::LAST_IDX);
            if (r_prep) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_addr == fhcg_pkg::LAST_IDX)) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_prep) begin
            r_limit <= n_limit;
            r_addr  <= '0;
            r_keep  <= '0;
            r_count <= '0;
        end else begin
            if (r_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_chk && kept) begin
                r_keep[r_chk_idx] <= 1'b1;
                r_count           <= r_count + 1'b1;
            end
        end
        r_chk_idx <= r_addr;
    end

    assign o_rd_addr = r_addr;
    assign o_done    = r_done;
    assign o_keep    = r_keep;
    assign o_count   = r_count;

endmodule

/* sv/first_hit_coincidence_gate.sv */
`timescale 1ns / 1ps

// First-hit coincidence gate. Each input beat carries one crystal hit of an event; the
// block stores the hit's calibrated time in a 64-entry memory, sets the raw and valid
// mask bits, and keeps the earliest valid time. The beat with tlast closes the event:
// the block then reads every stored time back, one crystal per cycle, and marks a valid
// and raw hit as kept when its time is at most the earliest time plus gate_ticks
// (correlated_mode 1) or later than that (correlated_mode 0). The result beat carries
// the keep mask, the number kept and an accept flag set when two or more hits survive.
// Hits load at one beat per cycle while the input is ready; after the tlast beat the input
// is held off while the evaluation pass walks the time memory through its single read port,
// one entry a cycle, and for longer if an earlier result still waits in the output
// register. The result sits in that output register, so the next event may load while
// it waits to be taken. Configuration is written through a plain write port (index 0
// gate_ticks, index 1 correlated_mode); write it only while the block is idle, which it does not enforce.
module first_hit_coincidence_gate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input beat, tdata from bit 0: crystal[5:0], raw_hit, cal_valid, hit_time[31:0].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fhcg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    // Result beat, tdata from bit 0: keep_mask[63:0], kept_count[6:0], accept.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fhcg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [fhcg_pkg::GATE_W-1:0]         i_cfg_data
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [fhcg_pkg::GATE_W-1:0]     r_gate_ticks;
    logic                            r_correlated;
    logic                            r_out_valid;
    logic [fhcg_pkg::MASK_W-1:0]     r_out_keep;
    logic [fhcg_pkg::COUNT_W-1:0]    r_out_count;
    logic                            r_out_accept;

    logic                            in_beat;
    logic                            push;
    logic                            out_free;
    fhcg_pkg::t_event                evt;
    fhcg_pkg::t_ram_wr               wr;
    logic [fhcg_pkg::CRYSTAL_W-1:0]  rd_addr;
    logic [fhcg_pkg::TIME_W-1:0]     rd_data;
    logic                            scan_done;
    logic [fhcg_pkg::MASK_W-1:0]     scan_keep;
    logic [fhcg_pkg::COUNT_W-1:0]    scan_count;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign push          = (r_state == ST_PUSH) && out_free;

    // Control sequence: load hits, evaluate, hand the result to the output register.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_beat && s_axis_tlast) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_gate_ticks <= '0;
            r_correlated <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fhcg_pkg::CFG_GATE_TICKS:      r_gate_ticks <= i_cfg_data;
                    fhcg_pkg::CFG_CORRELATED_MODE: r_correlated <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_keep   <= scan_keep;
            r_out_count  <= scan_count;
            r_out_accept <= (scan_count >= fhcg_pkg::COUNT_W'(fhcg_pkg::MIN_SURVIVORS));
        end
    end

    fhcg_event u_event (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (in_beat),
        .i_clear     (push),
        .i_crystal   (s_axis_tdata[5:0]),
        .i_raw_hit   (s_axis_tdata[6]),
        .i_cal_valid (s_axis_tdata[7]),
        .i_hit_time  (s_axis_tdata[39:8]),
        .o_evt       (evt),
        .o_wr        (wr)
    );

    fhcg_ram #(
        .WIDTH (fhcg_pkg::TIME_W),
        .DEPTH (fhcg_pkg::MASK_W)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    fhcg_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_beat && s_axis_tlast),
        .i_gate_ticks (r_gate_ticks),
        .i_correlated (r_correlated),
        .i_evt        (evt),
        .i_rd_data    (rd_data),
        .o_rd_addr    (rd_addr),
        .o_done       (scan_done),
        .o_keep       (scan_keep),
        .o_count      (scan_count)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_accept, r_out_count, r_out_keep};

endmodule

/* sv/fhcg_checker.sv */
`timescale 1ns / 1ps

module fhcg_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                s_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [fhcg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // An event's closing beat starts the evaluation pass, which holds off input.
    a_close_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still taken after the closing beat");

    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[63:0]) == int'(m_axis_tdata[70:64])))
        else $error("kept count disagrees with keep mask");

    a_accept_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71] == (m_axis_tdata[70:64] >= 7'd2)))
        else $error("accept flag disagrees with kept count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind first_hit_coincidence_gate fhcg_checker u_fhcg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
